// ----- rtl/ukf_pkg.sv -----
`default_nettype none

package ukf_pkg;

  // Default sizes
  localparam int UKF_DEPTH      = 16;
  localparam int UKF_KEY_BITS   = 32;
  localparam int UKF_VALUE_BITS = 32;

  localparam int STATUS_W = 3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEQ   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd4;

  // Operation kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic shift;   // dequeue: every cell takes its upper neighbor's contents
    logic enq;     // enqueue: first free cell loads the incoming item
  } ukf_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ukf_cell.sv -----
`default_nettype none

module ukf_cell
  import ukf_pkg::*;
#(
  parameter int KEY_BITS   = UKF_KEY_BITS,
  parameter int VALUE_BITS = UKF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ukf_ctrl_t             ctrl,
  input  wire logic                  prev_valid,   // lower neighbor holds an entry
  input  wire logic                  nbr_valid,    // upper neighbor contents
  input  wire logic [KEY_BITS-1:0]   nbr_key,
  input  wire logic [VALUE_BITS-1:0] nbr_value,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       valid,
  output logic [KEY_BITS-1:0]        key,
  output logic [VALUE_BITS-1:0]      value,
  output logic                       hit
);

  logic                  valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  load;

  // This cell is the first free one in the chain
  assign load = ctrl.enq & ~valid_r & prev_valid;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = nbr_valid;
      key_nxt   = nbr_key;
      value_nxt = nbr_value;
    end else if (load) begin
      valid_nxt = 1'b1;
      key_nxt   = in_key;
      value_nxt = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  // Key match against an occupied cell
  assign hit   = valid_r & (key_r == in_key);
  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

`default_nettype wire

// ----- rtl/unique_key_fifo_unit.sv -----
`default_nettype none

// unique_key_fifo_unit: FIFO of key/value entries that refuses duplicate keys.
// Input channel: in_kind (0 enqueue, 1 dequeue), in_entry_key, in_entry_value.
//   An item is taken at a clock edge with start high and busy low; busy never
//   rises, so one item can be taken every cycle.
// Result channel: out_strobe marks one cycle carrying out_status, out_key,
//   out_value, out_occupancy and out_is_empty. Each item gives one result,
//   registered, in the cycle after the item is taken.
// Throughput is one item per cycle. Storage is a chain of DEPTH cells with
//   the oldest entry in cell 0: a dequeue shifts the whole chain down one
//   cell, an enqueue loads the first free cell. Every cell compares its key
//   with the incoming one, so the duplicate check finishes in that cycle.
// Status: 0 enqueued, 1 duplicate key, 2 full, 3 dequeued, 4 underflow.
//   A duplicate wins over full. out_key/out_value are zero except on dequeue.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; stored payload is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module unique_key_fifo_unit
  import ukf_pkg::*;
#(
  parameter int DEPTH      = UKF_DEPTH,
  parameter int KEY_BITS   = UKF_KEY_BITS,
  parameter int VALUE_BITS = UKF_VALUE_BITS,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_kind,
  input  wire logic [KEY_BITS-1:0]   in_entry_key,
  input  wire logic [VALUE_BITS-1:0] in_entry_value,
  output logic                       out_strobe,
  output logic [STATUS_W-1:0]        out_status,
  output logic [KEY_BITS-1:0]        out_key,
  output logic [VALUE_BITS-1:0]      out_value,
  output logic [CNT_W-1:0]           out_occupancy,
  output logic                       out_is_empty
);

  logic                  cell_valid [DEPTH];
  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]      cell_hit;

  logic                  take;
  logic                  dup, full, empty;
  ukf_ctrl_t             ctrl;
  logic [STATUS_W-1:0]   status;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  strobe_r;
  logic [STATUS_W-1:0]   status_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CNT_W-1:0]      occ_r;
  logic                  empty_r;

  assign busy = 1'b0;
  assign take = start & ~busy;

  assign dup   = |cell_hit;
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // Decode the operation
  always_comb begin
    ctrl    = '0;
    cnt_nxt = cnt_r;
    status  = ST_UNDER;
    if (in_kind == KIND_ENQ) begin
      if (dup) begin
        status = ST_DUP;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status   = ST_ENQ;
        ctrl.enq = take;
        if (take) cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status = ST_UNDER;
      end else begin
        status     = ST_DEQ;
        ctrl.shift = take;
        if (take) cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_v;
    logic                  nbr_v;
    logic [KEY_BITS-1:0]   nbr_k;
    logic [VALUE_BITS-1:0] nbr_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nbr_v = 1'b0;
      assign nbr_k = '0;
      assign nbr_d = '0;
    end else begin : g_inner
      assign nbr_v = cell_valid[i+1];
      assign nbr_k = cell_key[i+1];
      assign nbr_d = cell_value[i+1];
    end

    ukf_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .nbr_valid  (nbr_v),
      .nbr_key    (nbr_k),
      .nbr_value  (nbr_d),
      .in_key     (in_entry_key),
      .in_value   (in_entry_value),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .hit        (cell_hit[i])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= take;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status;
      key_r    <= (status == ST_DEQ) ? cell_key[0] : '0;
      value_r  <= (status == ST_DEQ) ? cell_value[0] : '0;
      occ_r    <= cnt_nxt;
      empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_key       = key_r;
  assign out_value     = value_r;
  assign out_occupancy = occ_r;
  assign out_is_empty  = empty_r;

endmodule

`default_nettype wire
